@@ sv/lep_pkg.sv @@
// Shared types and constants for the Lyapunov exponent pixel unit.
package lep_pkg;

   typedef struct packed {
      logic [25:0] rate_a;
      logic [25:0] rate_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [21:0] exponent;
      logic               saturated;
   } rsp_payload_type;

   localparam logic [1:0] CSR_PATTERN_BITS   = 2'd0;
   localparam logic [1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [1:0] CSR_STEP_COUNT     = 2'd2;

   localparam logic [15:0] RST_PATTERN_BITS   = 16'd116;
   localparam logic [4:0]  RST_PATTERN_LENGTH = 5'd8;
   localparam logic [15:0] RST_STEP_COUNT     = 16'd1000;

   // fractional bits of rates and orbit value
   localparam int FRAC_BITS = 24;

   // ln2 in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam int LOG_FRAC = 20;
   localparam logic signed [47:0] TERM_MIN = -48'sd2097152;
   localparam logic signed [47:0] EXP_MIN  = -48'sd2097152;
   localparam logic signed [47:0] EXP_MAX  = 48'sd2097151;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_V,
      ST_MUL_M,
      ST_NORM,
      ST_SQUARE,
      ST_LN,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_p;
      logic mul_v;
      logic mul_m;
      logic norm;
      logic square;
      logic ln;
      logic acc;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic zero_steps;
      logic steps_left;
      logic square_last;
      logic div_last;
   } status_type;

endpackage

@@ sv/lep_ctrl.sv @@
// Sequencer for the orbit iteration, log evaluation and final divide.
module lep_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lep_pkg::status_type   status,
   output lep_pkg::cmd_type      cmd
);

   lep_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lep_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         lep_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.zero_steps ? lep_pkg::ST_DIV : lep_pkg::ST_MUL_P;
               cmd.div_start = status.zero_steps;
            end
         end
         lep_pkg::ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = lep_pkg::ST_MUL_V;
         end
         lep_pkg::ST_MUL_V: begin
            cmd.mul_v = 1'b1;
            state_in  = lep_pkg::ST_MUL_M;
         end
         lep_pkg::ST_MUL_M: begin
            cmd.mul_m = 1'b1;
            state_in  = lep_pkg::ST_NORM;
         end
         lep_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = lep_pkg::ST_SQUARE;
         end
         lep_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            if (status.square_last) begin
               state_in = lep_pkg::ST_LN;
            end
         end
         lep_pkg::ST_LN: begin
            cmd.ln   = 1'b1;
            state_in = lep_pkg::ST_ACC;
         end
         lep_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.steps_left) begin
               state_in = lep_pkg::ST_MUL_P;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = lep_pkg::ST_DIV;
            end
         end
         lep_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = lep_pkg::ST_DONE;
            end
         end
         lep_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            rsp_valid  = 1'b1;
            if (!rsp_stall) begin
               state_in = lep_pkg::ST_IDLE;
            end
         end
         default: state_in = lep_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ sv/lep_datapath.sv @@
// Orbit, log and mean datapath with a serial log unit and serial divider.
module lep_datapath #(
   parameter int MAX_PATTERN_LEN = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lep_pkg::cmd_type          cmd,
   output lep_pkg::status_type       status,
   input  lep_pkg::req_payload_type  req_payload,
   input  logic [15:0]               pattern_bits,
   input  logic [4:0]                pattern_length,
   input  logic [15:0]               step_count,
   output lep_pkg::rsp_payload_type  rsp_payload
);

   localparam int FRAC_BITS = lep_pkg::FRAC_BITS;
   localparam int RW = FRAC_BITS + 2;        // rate width
   localparam int VW = FRAC_BITS + 1;        // orbit width, up to 1.0
   localparam int PW = $clog2(MAX_PATTERN_LEN + 1);
   localparam int IW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

   logic [RW-1:0] rate_a_ff, rate_b_ff;
   logic [VW-1:0] v_ff, v_in;
   logic [VW-1:0] p_ff;
   logic [RW:0]   m_ff;                      // m < 2^(F+2)
   logic [31:0]   x_ff, x_in;
   logic [4:0]    sq_ff;
   logic signed [31:0] lg_ff;
   logic signed [47:0] term_ff;
   logic signed [47:0] sum_ff;
   logic [PW-1:0] pos_ff;
   logic [15:0]   steps_ff;
   logic          sat_ff;
   logic [47:0]   rem_ff, quo_ff;
   logic [5:0]    div_cnt_ff;
   logic          neg_ff;

   logic [PW-1:0] len_eff;
   logic          use_b;
   logic [RW-1:0] r_cur;
   logic [VW-1:0] distance;
   logic [2*VW+1:0] prod_p;
   logic [RW+VW-1:0] prod_v;
   logic [RW+VW-1:0] prod_m;
   logic [63:0]   sq;
   logic [5:0]    e_det;
   logic [63:0]   m_wide;
   logic [48:0]   rem_shift;
   logic signed [47:0] mean;
   logic signed [63:0] ln_prod;
   logic [63:0]   ln_mag;
   logic signed [47:0] sum_in;
   logic signed [47:0] div_src;

   always_comb begin
      if (pattern_length == 5'd0) begin
         len_eff = PW'(1);
      end else if (32'(pattern_length) > MAX_PATTERN_LEN) begin
         len_eff = PW'(MAX_PATTERN_LEN);
      end else begin
         len_eff = PW'(pattern_length);
      end
      use_b = (32'(pos_ff) < 16) ? pattern_bits[pos_ff[IW-1:0] & 4'hF] : 1'b0;
      r_cur = use_b ? rate_b_ff : rate_a_ff;
   end

   // shared-style multiplies, one per state
   assign prod_p = (2*VW+2)'(v_ff) * (2*VW+2)'(ONE - v_ff);
   assign prod_v = (RW+VW)'(r_cur) * (RW+VW)'(p_ff);
   assign distance = ({v_ff, 1'b0} >= {1'b0, ONE}) ? VW'({v_ff, 1'b0} - {1'b0, ONE})
                                                   : VW'({1'b0, ONE} - {v_ff, 1'b0});
   assign prod_m = (RW+VW)'(r_cur) * (RW+VW)'(distance);
   assign sq     = 64'(x_ff) * 64'(x_ff);

   always_comb begin
      logic [RW+VW-1:0] vn;
      vn   = prod_v >> FRAC_BITS;
      v_in = (vn > (RW+VW)'(ONE)) ? ONE : VW'(vn);
   end

   // leading one search over m
   always_comb begin
      e_det = '0;
      for (int i = 0; i <= RW; i++) begin
         if (m_ff[i]) begin
            e_det = 6'(i);
         end
      end
      m_wide = 64'(m_ff);
   end

   always_comb begin
      logic [63:0] s;
      s    = sq >> 30;
      x_in = (s >= 64'h8000_0000) ? 32'(s >> 1) : 32'(s);
   end

   assign ln_prod = 64'(lg_ff) * $signed({32'd0, lep_pkg::LN2_Q32}) + (64'sd1 <<< 35);
   assign ln_mag  = (ln_prod >= 0) ? 64'(ln_prod) : 64'(-ln_prod);

   assign rem_shift = {rem_ff, quo_ff[47]};

   // the divide after the last step starts from the sum updated that edge
   assign sum_in  = sum_ff + ((m_ff == '0) ? lep_pkg::TERM_MIN : term_ff);
   assign div_src = cmd.acc ? sum_in : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         pos_ff   <= '0;
         sq_ff    <= '0;
         div_cnt_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            steps_ff <= '0;
            pos_ff   <= '0;
            sat_ff   <= 1'b0;
         end
         if (cmd.norm) begin
            sq_ff <= '0;
         end
         if (cmd.square) begin
            sq_ff <= sq_ff + 5'd1;
         end
         if (cmd.acc) begin
            steps_ff <= steps_ff + 16'd1;
            pos_ff   <= (pos_ff + PW'(1) >= len_eff) ? '0 : pos_ff + PW'(1);
            if (m_ff == '0) begin
               sat_ff <= 1'b1;
            end
         end
         if (cmd.div_start) begin
            div_cnt_ff <= '0;
         end
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         if (cmd.finish) begin
            if (mean < lep_pkg::EXP_MIN || mean > lep_pkg::EXP_MAX) begin
               sat_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rate_a_ff <= req_payload.rate_a[RW-1:0];
         rate_b_ff <= req_payload.rate_b[RW-1:0];
         v_ff      <= ONE >> 1;
         sum_ff    <= '0;
      end
      if (cmd.mul_p) begin
         p_ff <= VW'(prod_p >> FRAC_BITS);
      end
      if (cmd.mul_v) begin
         v_ff <= v_in;
      end
      if (cmd.mul_m) begin
         m_ff <= (RW+1)'(prod_m >> FRAC_BITS);
      end
      if (cmd.norm) begin
         x_ff  <= (e_det >= 6'd30) ? 32'(m_wide >> (e_det - 6'd30))
                                  : 32'(m_wide << (6'd30 - e_det));
         lg_ff <= (32'(signed'({26'd0, e_det})) - 32'(FRAC_BITS)) <<< lep_pkg::LOG_FRAC;
      end
      if (cmd.square) begin
         x_ff <= x_in;
         if (sq_ff < 5'(lep_pkg::LOG_FRAC) && (sq >> 30) >= 64'h8000_0000) begin
            lg_ff <= lg_ff + (32'sd1 <<< (lep_pkg::LOG_FRAC - 1 - int'(sq_ff)));
         end
      end
      if (cmd.ln) begin
         term_ff <= (ln_prod >= 0) ? 48'(ln_mag >> 36)
                                   : -48'((ln_mag + 64'hF_FFFF_FFFF) >> 36);
      end
      if (cmd.acc) begin
         sum_ff <= sum_in;
      end
      if (cmd.div_start) begin
         neg_ff <= div_src[47];
         rem_ff <= '0;
         quo_ff <= div_src[47] ? 48'(-div_src) : 48'(div_src);
      end
      if (cmd.div_step) begin
         if (step_count == 16'd0) begin
            quo_ff <= '0;
            rem_ff <= '0;
         end else begin
            if (rem_shift >= 49'(step_count)) begin
               rem_ff <= 48'(rem_shift - 49'(step_count));
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= rem_shift[47:0];
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
         end
      end
   end

   assign mean = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_comb begin
      logic signed [47:0] clamped;
      if (mean < lep_pkg::EXP_MIN) begin
         clamped = lep_pkg::EXP_MIN;
      end else if (mean > lep_pkg::EXP_MAX) begin
         clamped = lep_pkg::EXP_MAX;
      end else begin
         clamped = mean;
      end
      rsp_payload.exponent  = clamped[21:0];
      rsp_payload.saturated = sat_ff || (mean < lep_pkg::EXP_MIN) || (mean > lep_pkg::EXP_MAX);
   end

   assign status.zero_steps  = (step_count == 16'd0);
   assign status.steps_left  = (steps_ff + 16'd1 < step_count);
   assign status.square_last = (sq_ff == 5'(lep_pkg::LOG_FRAC - 1));
   assign status.div_last    = (div_cnt_ff == 6'd47);

endmodule

@@ sv/lyapunov_exponent_pixel_unit.sv @@
// Top level: one point in, one Lyapunov exponent out.
// Each step runs 6 states plus 20 squarings of the log unit, then a 48-step
// restoring divide forms the mean. One point at a time: a new request is taken
// only after the previous response is accepted. Reset is synchronous; state,
// counters and configuration registers return to defaults.
module lyapunov_exponent_pixel_unit #(
   parameter int MAX_PATTERN_LEN = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lep_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lep_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_data
);

   logic [15:0] pattern_bits_ff;
   logic [4:0]  pattern_length_ff;
   logic [15:0] step_count_ff;
   lep_pkg::cmd_type    cmd;
   lep_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bits_ff   <= lep_pkg::RST_PATTERN_BITS;
         pattern_length_ff <= lep_pkg::RST_PATTERN_LENGTH;
         step_count_ff     <= lep_pkg::RST_STEP_COUNT;
      end else if (csr_write) begin
         case (csr_index)
            lep_pkg::CSR_PATTERN_BITS:   pattern_bits_ff   <= csr_data;
            lep_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[4:0];
            lep_pkg::CSR_STEP_COUNT:     step_count_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   lep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lep_datapath #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_payload    (req_payload),
      .pattern_bits   (pattern_bits_ff),
      .pattern_length (pattern_length_ff),
      .step_count     (step_count_ff),
      .rsp_payload    (rsp_payload)
   );

endmodule

@@ test/lyapunov_exponent_pixel_unit_checker.sv @@
// Checker for the Lyapunov exponent unit: tracks registers, predicts and compares responses.
module lyapunov_exponent_pixel_unit_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  lep_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  lep_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = lep_pkg::FRAC_BITS;
   localparam int MAX_LEN = 16;

   logic [15:0] pattern_bits;
   logic [4:0]  pattern_length;
   logic [15:0] step_count;
   lep_pkg::rsp_payload_type exponent_queue[$];

   // natural log of m / 2^FRAC, Q.16
   function automatic longint ln_q16(logic [63:0] m);
      int e;
      logic [63:0] x;
      longint lg, prod;
      e = 63;
      while (e > 0 && !m[e]) e--;
      x = (e >= 30) ? (m >> (e - 30)) : (m << (30 - e));
      lg = longint'(e - FRAC) * (longint'(1) << lep_pkg::LOG_FRAC);
      for (int i = 1; i <= lep_pkg::LOG_FRAC; i++) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            lg += longint'(1) << (lep_pkg::LOG_FRAC - i);
         end
      end
      prod = lg * longint'({32'd0, lep_pkg::LN2_Q32}) + (longint'(1) << 35);
      if (prod >= 0) return prod >>> 36;
      return -((-prod + ((longint'(1) << 36) - 1)) >>> 36);
   endfunction

   function automatic lep_pkg::rsp_payload_type lyapunov_point(logic [25:0] ra,
                                                               logic [25:0] rb);
      logic [63:0] one, v, p, r, distance, m;
      longint sum, mean;
      int len, pos;
      logic sat;
      lep_pkg::rsp_payload_type res;
      one = 64'd1 << FRAC;
      v = one >> 1;
      sum = 0;
      pos = 0;
      sat = 1'b0;
      len = (pattern_length == 0) ? 1 : int'(pattern_length);
      if (len > MAX_LEN) len = MAX_LEN;
      for (int k = 0; k < int'(step_count); k++) begin
         r = (pos < 16 && pattern_bits[pos]) ? {38'd0, rb} : {38'd0, ra};
         p = (v * (one - v)) >> FRAC;
         v = (r * p) >> FRAC;
         if (v > one) v = one;
         distance = (2 * v >= one) ? 2 * v - one : one - 2 * v;
         m = (r * distance) >> FRAC;
         if (m == 0) begin
            sum += longint'(lep_pkg::TERM_MIN);
            sat = 1'b1;
         end else begin
            sum += ln_q16(m);
         end
         pos++;
         if (pos >= len) pos = 0;
      end
      mean = (step_count == 0) ? 0 : sum / longint'({48'd0, step_count});
      if (mean < longint'(lep_pkg::EXP_MIN)) begin
         mean = longint'(lep_pkg::EXP_MIN);
         sat = 1'b1;
      end
      if (mean > longint'(lep_pkg::EXP_MAX)) begin
         mean = longint'(lep_pkg::EXP_MAX);
         sat = 1'b1;
      end
      res.exponent = mean[21:0];
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      lep_pkg::rsp_payload_type want;
      int errs;
      errs = 0;
      if (reset) begin
         pattern_bits <= lep_pkg::RST_PATTERN_BITS;
         pattern_length <= lep_pkg::RST_PATTERN_LENGTH;
         step_count <= lep_pkg::RST_STEP_COUNT;
         exponent_queue.delete();
         failures <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lep_pkg::CSR_PATTERN_BITS:   pattern_bits <= csr_data;
               lep_pkg::CSR_PATTERN_LENGTH: pattern_length <= csr_data[4:0];
               lep_pkg::CSR_STEP_COUNT:     step_count <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            exponent_queue.push_back(lyapunov_point(req_payload.rate_a, req_payload.rate_b));
         if (rsp_valid && !rsp_stall) begin
            if (exponent_queue.size() == 0) begin
               $error("response with no request outstanding: exponent %0d saturated %0b",
                      rsp_payload.exponent, rsp_payload.saturated);
               errs++;
            end else begin
               want = exponent_queue.pop_front();
               if (rsp_payload.exponent !== want.exponent) begin
                  $error("exponent: expected %0d, got %0d", want.exponent, rsp_payload.exponent);
                  errs++;
               end
               if (rsp_payload.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated,
                         rsp_payload.saturated);
                  errs++;
               end
            end
         end
         failures <= failures + errs;
      end
   end

   assign pending = exponent_queue.size();
endmodule

@@ test/lyapunov_exponent_pixel_unit_test.sv @@
// Testbench top for the Lyapunov exponent unit: clock, stimulus and verdict.
module lyapunov_exponent_pixel_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [25:0] RATE_MAX = 26'h3FFFFFF;
   localparam logic [25:0] RATE_ONE = 26'h1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lep_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lep_pkg::rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = lep_pkg::CSR_PATTERN_BITS;
   logic [15:0] csr_data = '0;
   int failures, pending;
   int requests_sent = 0;
   int configs_used = 0;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;

   lyapunov_exponent_pixel_unit uut (.*);
   lyapunov_exponent_pixel_unit_checker exponent_check (.*);

   always #4 clock = ~clock;

   // response side: random stall bursts, one long hold on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_point(logic [25:0] ra, logic [25:0] rb);
      req_valid <= 1'b1;
      req_payload <= '{rate_a: ra, rate_b: rb};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (!quiet && $urandom_range(0, 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_mode(logic [15:0] bits, logic [15:0] len, logic [15:0] steps);
      drain();
      csr_write <= 1'b1;
      csr_index <= lep_pkg::CSR_PATTERN_BITS;
      csr_data <= bits;
      @(posedge clock);
      csr_index <= lep_pkg::CSR_PATTERN_LENGTH;
      csr_data <= len;
      @(posedge clock);
      csr_index <= lep_pkg::CSR_STEP_COUNT;
      csr_data <= steps;
      @(posedge clock);
      csr_write <= 1'b0;
      configs_used++;
   endtask

   // chaotic region mostly, full range sometimes
   function automatic logic [25:0] pick_rate();
      if ($urandom_range(0, 3) == 0) return 26'($urandom()) & RATE_MAX;
      return 26'($urandom_range(26'h2800000, RATE_MAX));
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // power-on settings
      send_point(26'h3800000, 26'h3400000);
      send_point(RATE_ONE, RATE_MAX);
      set_mode(16'h0000, 16'd1, 16'd1);
      send_point(26'd0, 26'd0);
      send_point(RATE_MAX, RATE_MAX);
      send_point(26'h2000000, 26'h2000000);  // derivative exactly zero
      send_point(RATE_ONE, 26'd0);
      set_mode(16'hFFFF, 16'd16, 16'd1);
      send_point(26'd0, RATE_MAX);
      send_point(RATE_MAX, 26'd1);
      set_mode(16'h0000, 16'd0, 16'd0);      // zero steps, zero length
      send_point(RATE_MAX, RATE_MAX);
      send_point(26'h1555555, 26'h2AAAAAA);
      set_mode(16'hA5C3, 16'd31, 16'd40);    // length above the maximum
      send_point(26'h3A00000, 26'h2C00000);
      send_point(26'h2000000, 26'h3F00000);
      send_point(26'd1, 26'd1);
      set_mode(16'hFFFF, 16'd17, 16'd33);
      send_point(RATE_MAX, 26'h3000000);
      send_point(26'h3000000, 26'h2000000);
      // input backs up behind a long response hold
      hold_off = 1'b1;
      for (int i = 0; i < 5; i++) send_point(pick_rate(), pick_rate());
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         set_mode(16'($urandom()), 16'($urandom_range(0, 31)),
                  16'($urandom_range(1, 30)));
         if (phase == 5) quiet = 1'b1;
         for (int i = 0; i < 20; i++) send_point(pick_rate(), pick_rate());
      end
      set_mode(16'h6C2B, 16'd16, 16'hFFFF);  // longest orbit, one point
      send_point(26'h3B00000, 26'h3500000);
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d requests over %0d register settings, rates from 0 to just under 4.0",
               requests_sent, configs_used + 1);
      $display("including zero steps, zero derivatives, odd pattern lengths and a long hold");
      if (failures == 0)
         $display("lyapunov_exponent_pixel_unit_test passed");
      else
         $display("lyapunov_exponent_pixel_unit_test failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("lyapunov_exponent_pixel_unit_test failed");
      $finish;
   end
endmodule
